/* design/cemb_pkg.sv */
// cemb_pkg: shared constants, codes and controller/datapath link types
// for the channel to extended memory bridge
// no dependencies
package cemb_pkg;

  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  localparam int unsigned CHAN_W    = 12;
  localparam int unsigned WORD_W    = 60;
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [SIZE_W-1:0] MEM_SIZE_RESET = SIZE_W'(MEM_WORDS);

  // function codes
  localparam logic [CHAN_W-1:0] FN_READ   = 12'o5001;
  localparam logic [CHAN_W-1:0] FN_WRITE  = 12'o5002;
  localparam logic [CHAN_W-1:0] FN_STATUS = 12'o5004;
  localparam logic [CHAN_W-1:0] FN_CLEAR  = 12'o5010;

  // status codes
  localparam logic [1:0] ST_ABORT  = 2'b01;
  localparam logic [1:0] ST_ACCEPT = 2'b10;

  // address control bits
  localparam int unsigned ADDR_READ_ONE_BIT = 22;
  localparam int unsigned ADDR_FLAG_BIT     = 23;

  typedef enum logic [1:0] {
    CMD_FUNC = 2'd0,
    CMD_DATA = 2'd1,
    CMD_REQ  = 2'd2,
    CMD_DISC = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_STATUS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REPLY_DECLINED  = 2'd0,
    REPLY_ACCEPTED  = 2'd1,
    REPLY_PROCESSED = 2'd2
  } reply_e;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_busy;
  } dp_status_t;

endpackage

/* design/cemb_ctrl.sv */
// cemb_ctrl: sequencer for memory clear, item load and execute
// depends on cemb_pkg
module cemb_ctrl
  import cemb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (status_i.clr_done) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (!status_i.out_busy) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_CLEAR;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o   = ready_q;
  assign cmd_o.clr_en = (state_q == S_CLEAR);
  assign cmd_o.load   = in_valid_i && ready_q;
  assign cmd_o.exec   = (state_q == S_EXEC) && !status_i.out_busy;

endmodule

/* design/cemb_datapath.sv */
// cemb_datapath: transfer state, word memory, address checks and result register
// depends on cemb_pkg; driven by cemb_ctrl
module cemb_datapath
  import cemb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             status_o,
  input  logic [1:0]             in_cmd_i,
  input  logic [CHAN_W-1:0]      in_word_i,
  input  logic                   in_grant_i,
  input  logic                   cfg_we_i,
  input  logic [SIZE_W-1:0]      cfg_wdata_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  // word memory
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic [MEM_AW-1:0] clr_cnt_q;

  // item registers
  cmd_e              cmd_q;
  logic [CHAN_W-1:0] word_q;
  logic              grant_q;

  // transfer state
  logic [SIZE_W-1:0] mem_size_q;
  mode_e             func_q, func_d;
  logic [WORD_W-1:0] buf_q, buf_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [1:0]        abs_q, abs_d;
  logic [2:0]        dbi_q, dbi_d;
  logic              fetch_q, fetch_d;
  logic [1:0]        stat_q, stat_d;

  // result register
  logic                   oval_q;
  logic [OUT_TDATA_W-1:0] odata_q;

  logic              r_valid, r_disc, r_drop;
  logic [CHAN_W-1:0] r_word;
  reply_e            r_reply;

  logic              do_store, st_we;
  logic [WORD_W-1:0] st_buf;
  logic [WORD_W-1:0] buf_e;
  logic [ADDR_W-1:0] addr_n;
  logic [2:0]        dbi_e;
  logic              addr_ok;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [WORD_W-1:0] mem_wd;

  assign addr_ok = (addr_q < {{(ADDR_W-SIZE_W){1'b0}}, mem_size_q})
                && (addr_q < ADDR_W'(MEM_WORDS));

  always_comb begin
    func_d   = func_q;
    buf_d    = buf_q;
    addr_d   = addr_q;
    abs_d    = abs_q;
    dbi_d    = dbi_q;
    fetch_d  = fetch_q;
    stat_d   = stat_q;
    r_valid  = 1'b0;
    r_word   = '0;
    r_reply  = REPLY_DECLINED;
    r_disc   = 1'b0;
    r_drop   = 1'b0;
    do_store = 1'b0;
    st_we    = 1'b0;
    st_buf   = buf_q;
    buf_e    = buf_q;
    dbi_e    = dbi_q;
    addr_n   = {addr_q[ADDR_W-CHAN_W-1:0], word_q};

    unique case (cmd_q)
      CMD_FUNC: begin
        if (word_q == FN_READ || word_q == FN_WRITE || word_q == FN_STATUS) begin
          if (word_q == FN_WRITE) begin
            buf_d = '0;
          end
          abs_d   = '0;
          dbi_d   = '0;
          fetch_d = 1'b0;
          addr_d  = '0;
          func_d  = (word_q == FN_READ)  ? MODE_READ  :
                    (word_q == FN_WRITE) ? MODE_WRITE : MODE_STATUS;
          r_reply = REPLY_ACCEPTED;
        end else if (word_q == FN_CLEAR) begin
          func_d  = MODE_IDLE;
          stat_d  = ST_ACCEPT;
          r_reply = REPLY_PROCESSED;
        end
      end
      CMD_DATA: begin
        if (func_q == MODE_READ || func_q == MODE_WRITE) begin
          if (abs_q < 2'd2) begin
            addr_d = addr_n;
            abs_d  = abs_q + 2'd1;
            if (abs_q == 2'd1 && func_q == MODE_READ) begin
              if (addr_n[ADDR_FLAG_BIT]) begin
                if (grant_q) begin
                  stat_d = ST_ACCEPT;
                end else begin
                  r_disc = 1'b1;
                  stat_d = ST_ABORT;
                end
                dbi_d   = '0;
                fetch_d = 1'b0;
                buf_d   = '0;
              end else begin
                fetch_d = 1'b1;
              end
            end
          end else if (func_q == MODE_WRITE) begin
            stat_d = ST_ACCEPT;
            buf_d  = {buf_q[WORD_W-CHAN_W-1:0], word_q};
            dbi_d  = dbi_q + 3'd1;
            if (dbi_q + 3'd1 >= 3'd5) begin
              do_store = 1'b1;
              st_buf   = {buf_q[WORD_W-CHAN_W-1:0], word_q};
            end
          end
        end
      end
      CMD_REQ: begin
        if (func_q == MODE_STATUS) begin
          r_valid = 1'b1;
          r_word  = {{(CHAN_W-2){1'b0}}, stat_q};
          func_d  = MODE_IDLE;
        end else if (func_q == MODE_READ && abs_q >= 2'd2) begin
          if (fetch_q) begin
            if (addr_ok) begin
              buf_e  = rdata_q;
              stat_d = ST_ACCEPT;
            end else begin
              r_disc = 1'b1;
              stat_d = ST_ABORT;
            end
            fetch_d = 1'b0;
            dbi_e   = '0;
          end
          r_valid = 1'b1;
          r_word  = buf_e[WORD_W-1 -: CHAN_W];
          buf_d   = {buf_e[WORD_W-CHAN_W-1:0], {CHAN_W{1'b0}}};
          dbi_d   = dbi_e + 3'd1;
          if (dbi_e + 3'd1 >= 3'd5) begin
            if (addr_q[ADDR_READ_ONE_BIT] || addr_q[ADDR_FLAG_BIT]) begin
              r_disc = 1'b1;
            end
            fetch_d = 1'b1;
            dbi_d   = '0;
            addr_d  = addr_q + ADDR_W'(1);
          end
        end
      end
      CMD_DISC: begin
        if (func_q == MODE_WRITE && dbi_q != 3'd0) begin
          do_store = 1'b1;
          case (dbi_q)
            3'd1:    st_buf = {buf_q[WORD_W-4*CHAN_W-1:0], {(4*CHAN_W){1'b0}}};
            3'd2:    st_buf = {buf_q[WORD_W-3*CHAN_W-1:0], {(3*CHAN_W){1'b0}}};
            3'd3:    st_buf = {buf_q[WORD_W-2*CHAN_W-1:0], {(2*CHAN_W){1'b0}}};
            3'd4:    st_buf = {buf_q[WORD_W-CHAN_W-1:0], {CHAN_W{1'b0}}};
            default: st_buf = buf_q;
          endcase
        end
      end
      default: begin
      end
    endcase

    if (do_store) begin
      if (!addr_ok) begin
        r_drop = 1'b1;
        stat_d = ST_ABORT;
      end else begin
        st_we  = 1'b1;
        addr_d = addr_q + ADDR_W'(1);
      end
      buf_d = '0;
      dbi_d = '0;
    end
  end

  assign mem_we = cmd_i.clr_en || (cmd_i.exec && st_we);
  assign mem_wa = cmd_i.clr_en ? clr_cnt_q : addr_q[MEM_AW-1:0];
  assign mem_wd = cmd_i.clr_en ? '0 : st_buf;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.load) begin
      rdata_q <= mem[addr_q[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en && !status_o.clr_done) begin
      clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
    end
  end

  assign status_o.clr_done = (clr_cnt_q == MEM_AW'(MEM_WORDS - 1));
  assign status_o.out_busy = oval_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= cmd_e'(in_cmd_i);
      word_q  <= in_word_i;
      grant_q <= in_grant_i;
    end
    if (cmd_i.exec) begin
      odata_q <= {{(OUT_TDATA_W-17){1'b0}}, r_drop, r_disc, r_reply, r_word, r_valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= MEM_SIZE_RESET;
      func_q     <= MODE_IDLE;
      buf_q      <= '0;
      addr_q     <= '0;
      abs_q      <= '0;
      dbi_q      <= '0;
      fetch_q    <= 1'b0;
      stat_q     <= ST_ACCEPT;
      oval_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mem_size_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        func_q  <= func_d;
        buf_q   <= buf_d;
        addr_q  <= addr_d;
        abs_q   <= abs_d;
        dbi_q   <= dbi_d;
        fetch_q <= fetch_d;
        stat_q  <= stat_d;
        oval_q  <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;

endmodule

/* design/channel_to_extended_memory_bridge.sv */
// channel_to_extended_memory_bridge: top level of the channel to extended memory bridge
// depends on cemb_pkg, cemb_ctrl and cemb_datapath
//
//   port group    direction  contents
//   s_axis_*      in         channel item: cmd in tuser, chan_word and flag_grant in tdata
//   m_axis_*      out        one result item per channel item
//   cfg_*         in         memory_size register write
//
// an item is handled in a load step, which registers it and reads the memory word at the
// current address, then an execute step, which fills the output register
// after reset the memory is swept to zero, one word a cycle, all MEM_WORDS words
// (4096), with s_axis_tready low; configuration writes are taken throughout
// a full output register that is not taken holds the execute step
module channel_to_extended_memory_bridge
  import cemb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // chan_word, flag_grant, zero pad
  input  logic [1:0]             s_axis_tuser,   // cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_valid, out_word, func_reply,
                                                 // disc_after_input, channel_drop, zero pad
  input  logic                   cfg_we_i,
  input  logic [SIZE_W-1:0]      cfg_wdata_i
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  cemb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  cemb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .in_cmd_i    (s_axis_tuser),
    .in_word_i   (s_axis_tdata[CHAN_W-1:0]),
    .in_grant_i  (s_axis_tdata[CHAN_W]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* tb/testbench.sv */
// testbench for channel_to_extended_memory_bridge: random and directed channel items,
// results checked field by field against a cycle-free prediction of the bridge
// depends on cemb_pkg and the bridge rtl
`timescale 1ns / 1ps

module testbench;
  import cemb_pkg::*;

  typedef struct packed {
    cmd_e        cmd;
    logic [11:0] word;
    logic        grant;
  } chan_item_t;

  // same bit order as m_axis_tdata, lowest field last
  typedef struct packed {
    logic        drop;
    logic        disc;
    reply_e      reply;
    logic [11:0] word;
    logic        valid;
  } bridge_out_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // chan_word, flag_grant, zero pad
  logic [1:0]             s_axis_tuser = '0;   // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // out_valid, out_word, func_reply,
                                               // disc_after_input, channel_drop, zero pad
  logic                   cfg_we_i = 1'b0;
  logic [SIZE_W-1:0]      cfg_wdata_i = '0;

  channel_to_extended_memory_bridge i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // predicted bridge state
  logic [SIZE_W-1:0] mem_size;
  mode_e             mode;
  logic [59:0]       word_reg;
  logic [23:0]       word_addr;
  logic [1:0]        addr_cnt;
  logic [2:0]        byte_idx;
  logic              fetch_pend;
  logic [1:0]        status;
  logic [59:0]       ext_mem [MEM_WORDS];

  chan_item_t  chan_items_q[$];
  bridge_out_t expected_results_q[$];
  chan_item_t  next_item;
  bridge_out_t got, want;

  bit          in_took, out_took;
  bit          send_burst, recv_burst;
  int unsigned send_gap, recv_stall;
  int unsigned queued_items;
  int unsigned mismatch_count;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    if (mismatch_count < 40)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, exp_v, got_v);
    mismatch_count++;
  endtask

  function automatic bit addr_in_range(input logic [23:0] a);
    return (a < {11'd0, mem_size}) && (a < MEM_WORDS);
  endfunction

  function automatic void bridge_reset();
    mem_size   = MEM_SIZE_RESET;
    mode       = MODE_IDLE;
    word_reg   = '0;
    word_addr  = '0;
    addr_cnt   = '0;
    byte_idx   = '0;
    fetch_pend = 1'b0;
    status     = ST_ACCEPT;
    for (int i = 0; i < MEM_WORDS; i++) ext_mem[i] = '0;
  endfunction

  // returns the drop flag
  function automatic logic store_word();
    logic drop;
    drop = 1'b0;
    if (!addr_in_range(word_addr)) begin
      drop   = 1'b1;
      status = ST_ABORT;
    end else begin
      ext_mem[word_addr[MEM_AW-1:0]] = word_reg;
      word_addr = word_addr + 24'd1;
    end
    word_reg = '0;
    byte_idx = '0;
    return drop;
  endfunction

  function automatic bridge_out_t bridge_predict(input cmd_e cmd, input logic [11:0] w,
                                                 input logic grant);
    bridge_out_t r;
    int unsigned missing;
    r = '0;
    case (cmd)
      CMD_FUNC: begin
        if (w == FN_READ || w == FN_WRITE || w == FN_STATUS) begin
          if (w == FN_WRITE) word_reg = '0;
          addr_cnt   = '0;
          byte_idx   = '0;
          fetch_pend = 1'b0;
          word_addr  = '0;
          mode    = (w == FN_READ) ? MODE_READ : (w == FN_WRITE) ? MODE_WRITE : MODE_STATUS;
          r.reply = REPLY_ACCEPTED;
        end else if (w == FN_CLEAR) begin
          mode    = MODE_IDLE;
          status  = ST_ACCEPT;
          r.reply = REPLY_PROCESSED;
        end
      end
      CMD_DATA: begin
        if (mode == MODE_READ || mode == MODE_WRITE) begin
          if (addr_cnt < 2) begin
            word_addr = {word_addr[11:0], w};
            addr_cnt  = addr_cnt + 2'd1;
            if (addr_cnt == 2 && mode == MODE_READ) begin
              if (word_addr[ADDR_FLAG_BIT]) begin
                if (grant) begin
                  status = ST_ACCEPT;
                end else begin
                  r.disc = 1'b1;
                  status = ST_ABORT;
                end
                byte_idx   = '0;
                fetch_pend = 1'b0;
                word_reg   = '0;
              end else begin
                fetch_pend = 1'b1;
              end
            end
          end else if (mode == MODE_WRITE) begin
            status   = ST_ACCEPT;
            word_reg = {word_reg[47:0], w};
            byte_idx = byte_idx + 3'd1;
            if (byte_idx >= 5) r.drop = store_word();
          end
        end
      end
      CMD_REQ: begin
        if (mode == MODE_STATUS) begin
          r.valid = 1'b1;
          r.word  = {10'd0, status};
          mode    = MODE_IDLE;
        end else if (mode == MODE_READ && addr_cnt >= 2) begin
          if (fetch_pend) begin
            if (addr_in_range(word_addr)) begin
              word_reg = ext_mem[word_addr[MEM_AW-1:0]];
              status   = ST_ACCEPT;
            end else begin
              r.disc = 1'b1;
              status = ST_ABORT;
            end
            fetch_pend = 1'b0;
            byte_idx   = '0;
          end
          r.valid  = 1'b1;
          r.word   = word_reg[59:48];
          word_reg = {word_reg[47:0], 12'd0};
          byte_idx = byte_idx + 3'd1;
          if (byte_idx >= 5) begin
            if (word_addr[ADDR_READ_ONE_BIT] || word_addr[ADDR_FLAG_BIT]) r.disc = 1'b1;
            fetch_pend = 1'b1;
            byte_idx   = '0;
            word_addr  = word_addr + 24'd1;
          end
        end
      end
      default: begin
        if (mode == MODE_WRITE && byte_idx != 0) begin
          missing  = 5 - ((byte_idx < 5) ? byte_idx : 5);
          word_reg = word_reg << (12 * missing);
          r.drop   = store_word();
        end
      end
    endcase
    return r;
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_took) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (chan_items_q.size() > 0) begin
        next_item = chan_items_q.pop_front();
        s_axis_tdata  <= {3'b000, next_item.grant, next_item.word};
        s_axis_tuser  <= next_item.cmd;
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 9);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (recv_stall > 0) begin
        m_axis_tready <= 1'b0;
        recv_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // prediction on accepted items, checking on accepted results
  always @(posedge clk_i) begin
    in_took  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_took = rst_ni && m_axis_tvalid && m_axis_tready;
    if (in_took)
      expected_results_q.push_back(bridge_predict(cmd_e'(s_axis_tuser), s_axis_tdata[11:0],
                                                  s_axis_tdata[12]));
    if (out_took) begin
      got = bridge_out_t'(m_axis_tdata[16:0]);
      if (m_axis_tdata[23:17] != '0) report_mismatch("pad bits", 0, 32'(m_axis_tdata[23:17]));
      if (expected_results_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 32'(m_axis_tdata));
      end else begin
        want = expected_results_q.pop_front();
        if (got.valid != want.valid)
          report_mismatch("out_valid", 32'(want.valid), 32'(got.valid));
        if (got.word != want.word)
          report_mismatch("out_word", 32'(want.word), 32'(got.word));
        if (got.reply != want.reply)
          report_mismatch("func_reply", 32'(want.reply), 32'(got.reply));
        if (got.disc != want.disc)
          report_mismatch("disc_after_input", 32'(want.disc), 32'(got.disc));
        if (got.drop != want.drop)
          report_mismatch("channel_drop", 32'(want.drop), 32'(got.drop));
      end
    end
  end

  task automatic push_item(input cmd_e cmd, input logic [11:0] w, input logic g);
    chan_item_t it;
    it.cmd   = cmd;
    it.word  = w;
    it.grant = g;
    chan_items_q.push_back(it);
    queued_items++;
  endtask

  task automatic push_address();
    logic [23:0] a;
    case ($urandom_range(0, 9))
      6:       a = 24'(mem_size) + 24'($urandom_range(0, 2)) - 24'd1;
      7:       a = (24'($urandom_range(1, 3)) << ADDR_READ_ONE_BIT) | 24'($urandom_range(0, 47));
      8:       a = 24'($urandom);
      9:       a = 24'($urandom_range(0, 4095));
      default: a = 24'($urandom_range(0, 47));
    endcase
    push_item(CMD_DATA, a[23:12], 1'($urandom_range(0, 1)));
    push_item(CMD_DATA, a[11:0], 1'($urandom_range(0, 1)));
  endtask

  task automatic push_random_transfer();
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        push_item(CMD_FUNC, FN_WRITE, 1'($urandom_range(0, 1)));
        push_address();
        n = $urandom_range(1, 12);
        repeat (n) push_item(CMD_DATA, 12'($urandom_range(0, 4095)),
                             1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) push_item(CMD_DISC, 12'($urandom_range(0, 4095)), 1'b0);
      end
      4, 5, 6: begin
        push_item(CMD_FUNC, FN_READ, 1'($urandom_range(0, 1)));
        push_address();
        n = $urandom_range(1, 12);
        repeat (n) push_item(CMD_REQ, 12'($urandom_range(0, 4095)),
                             1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0) push_item(CMD_DISC, 12'($urandom_range(0, 4095)), 1'b1);
      end
      7: begin
        push_item(CMD_FUNC, FN_STATUS, 1'($urandom_range(0, 1)));
        push_item(CMD_REQ, 12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
      end
      8: begin
        push_item(CMD_FUNC, $urandom_range(0, 1) ? FN_CLEAR : 12'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)));
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) push_item(cmd_e'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                             1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  task automatic wait_drained();
    while (chan_items_q.size() != 0 || s_axis_tvalid || expected_results_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mem_size(input logic [SIZE_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    mem_size    = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [6];
    bridge_reset();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_mem_size(MEM_SIZE_RESET);

    // function codes: clear, declined extremes
    push_item(CMD_FUNC, FN_CLEAR, 1'b0);
    push_item(CMD_FUNC, 12'h000, 1'b0);
    push_item(CMD_FUNC, 12'hFFF, 1'b1);
    // write word 0, then a partial word padded by disconnect
    push_item(CMD_FUNC, FN_WRITE, 1'b0);
    push_item(CMD_DATA, 12'h000, 1'b0);
    push_item(CMD_DATA, 12'h000, 1'b0);
    push_item(CMD_REQ, 12'h000, 1'b0);
    push_item(CMD_DATA, 12'hFFF, 1'b1);
    push_item(CMD_DATA, 12'h000, 1'b0);
    push_item(CMD_DATA, 12'hAAA, 1'b0);
    push_item(CMD_DATA, 12'h555, 1'b1);
    push_item(CMD_DATA, 12'h123, 1'b0);
    push_item(CMD_DATA, 12'h800, 1'b0);
    push_item(CMD_DISC, 12'h000, 1'b0);
    // read back word 0 and the first byte of the padded word
    push_item(CMD_FUNC, FN_READ, 1'b0);
    push_item(CMD_DATA, 12'h000, 1'b0);
    push_item(CMD_REQ, 12'h000, 1'b0);
    push_item(CMD_DATA, 12'h000, 1'b0);
    repeat (6) push_item(CMD_REQ, 12'hFFF, 1'b0);
    // read-one address, out of range: abort with disconnect
    push_item(CMD_FUNC, FN_READ, 1'b0);
    push_item(CMD_DATA, 12'h400, 1'b0);
    push_item(CMD_DATA, 12'h000, 1'b0);
    push_item(CMD_REQ, 12'h000, 1'b0);
    // flag reference denied
    push_item(CMD_FUNC, FN_READ, 1'b0);
    push_item(CMD_DATA, 12'h800, 1'b0);
    push_item(CMD_DATA, 12'h000, 1'b0);
    push_item(CMD_REQ, 12'h000, 1'b0);
    // write past the end drops the channel
    push_item(CMD_FUNC, FN_WRITE, 1'b0);
    push_item(CMD_DATA, 12'h001, 1'b0);
    push_item(CMD_DATA, 12'h000, 1'b0);
    repeat (5) push_item(CMD_DATA, 12'h7FF, 1'b0);
    push_item(CMD_FUNC, FN_STATUS, 1'b0);
    push_item(CMD_REQ, 12'h000, 1'b0);

    sizes[0] = 13'd40;
    sizes[1] = 13'd0;
    sizes[2] = 13'd4096;
    sizes[3] = 13'($urandom_range(1, 4095));
    sizes[4] = 13'd1;
    sizes[5] = 13'd4096;
    foreach (sizes[p]) begin
      write_mem_size(sizes[p]);
      queued_items = 0;
      while (queued_items < 105) push_random_transfer();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
design/cemb_pkg.sv
design/cemb_ctrl.sv
design/cemb_datapath.sv
design/channel_to_extended_memory_bridge.sv
tb/testbench.sv
